// ----- sv/bsc_pkg.sv -----
// Shared types and constants for the barometric compensation pipeline.
package bsc_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIM       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LIN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_SQ_CUBE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFFSET    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFFSET_HI = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_QUAD      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH      = 3'd6;

	localparam logic signed [15:0] TEMP_MIN = -16'sd4000;
	localparam logic signed [15:0] TEMP_MAX = 16'sd8500;
	localparam logic [23:0] PRESS_MAX = 24'd16000000;

	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [23:0] raw_temperature;
	} sample_t;

	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic [23:0]        pressure_centi;
	} result_t;

	typedef struct packed {
		logic [15:0]        t1;
		logic [15:0]        t2;
		logic signed [7:0]  t3;
		logic signed [15:0] p1;
		logic signed [15:0] p2;
		logic signed [7:0]  p3;
		logic signed [7:0]  p4;
		logic [15:0]        p5;
		logic [15:0]        p6;
		logic signed [7:0]  p7;
		logic signed [7:0]  p8;
		logic signed [15:0] p9;
		logic signed [7:0]  p10;
		logic signed [7:0]  p11;
	} trim_t;

endpackage

// ----- sv/barometric_sensor_compensation_top.sv -----
// Top level: trim registers, pipeline control and the compensation stages.
// Throughput: one sample per cycle; the whole 13-stage pipeline advances when
// the output register is empty or its result is transferred in that cycle.
// Reset clears all trim registers to zero and all stage valid bits.
// Configuration writes are taken in every cycle (cfg_ready is always high).
module barometric_sensor_compensation_top import bsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  sample_t               sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned DEPTH = 13;

	logic [39:0] temp_trim_q;
	logic [31:0] press_lin_q;
	logic [15:0] press_sq_cube_q;
	logic [31:0] press_offset_q;
	logic [15:0] press_offset_hi_q;
	logic [15:0] press_quad_q;
	logic [15:0] press_high_q;
	trim_t       trim;

	logic [DEPTH-1:0] valid_s;
	logic             en;

	logic signed [27:0]  t_s5;
	logic signed [14:0]  tc_s13;
	logic signed [33:0]  c3_s5;
	logic signed [54:0]  c2_s6;
	logic signed [83:0]  c1_s8;
	logic signed [109:0] c0_s10;
	logic [23:0]         pc_s13;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q       <= '0;
			press_lin_q       <= '0;
			press_sq_cube_q   <= '0;
			press_offset_q    <= '0;
			press_offset_hi_q <= '0;
			press_quad_q      <= '0;
			press_high_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEMP_TRIM:       temp_trim_q       <= cfg_data[39:0];
				REG_PRESS_LIN:       press_lin_q       <= cfg_data[31:0];
				REG_PRESS_SQ_CUBE:   press_sq_cube_q   <= cfg_data[15:0];
				REG_PRESS_OFFSET:    press_offset_q    <= cfg_data[31:0];
				REG_PRESS_OFFSET_HI: press_offset_hi_q <= cfg_data[15:0];
				REG_PRESS_QUAD:      press_quad_q      <= cfg_data[15:0];
				REG_PRESS_HIGH:      press_high_q      <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		trim.t1  = temp_trim_q[15:0];
		trim.t2  = temp_trim_q[31:16];
		trim.t3  = $signed(temp_trim_q[39:32]);
		trim.p1  = $signed(press_lin_q[15:0]);
		trim.p2  = $signed(press_lin_q[31:16]);
		trim.p3  = $signed(press_sq_cube_q[7:0]);
		trim.p4  = $signed(press_sq_cube_q[15:8]);
		trim.p5  = press_offset_q[15:0];
		trim.p6  = press_offset_q[31:16];
		trim.p7  = $signed(press_offset_hi_q[7:0]);
		trim.p8  = $signed(press_offset_hi_q[15:8]);
		trim.p9  = $signed(press_quad_q);
		trim.p10 = $signed(press_high_q[7:0]);
		trim.p11 = $signed(press_high_q[15:8]);
	end

	// Every stage moves together; a held result freezes the whole pipeline.
	assign en = !valid_s[DEPTH-1] || result_ready;
	assign sample_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[DEPTH-2:0], sample_valid};
		end
	end

	bsc_temp u_temp (
		.clk             (clk),
		.en              (en),
		.raw_temperature (sample.raw_temperature),
		.trim            (trim),
		.t_s5            (t_s5),
		.tc_s13          (tc_s13)
	);

	bsc_coef u_coef (
		.clk          (clk),
		.en           (en),
		.raw_pressure (sample.raw_pressure),
		.trim         (trim),
		.c3_s5        (c3_s5),
		.c2_s6        (c2_s6),
		.c1_s8        (c1_s8),
		.c0_s10       (c0_s10)
	);

	bsc_horner u_horner (
		.clk    (clk),
		.en     (en),
		.t_s5   (t_s5),
		.c3_s5  (c3_s5),
		.c2_s6  (c2_s6),
		.c1_s8  (c1_s8),
		.c0_s10 (c0_s10),
		.pc_s13 (pc_s13)
	);

	assign result_valid = valid_s[DEPTH-1];
	assign result.temperature_centi = tc_s13;
	assign result.pressure_centi = pc_s13;

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> valid_s[0])
		else $error("accepted sample did not enter the first stage");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("pipeline refused a sample while the output was empty");

	a_press_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.pressure_centi <= PRESS_MAX)
		else $error("pressure result above saturation limit");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (16'(result.temperature_centi) >= TEMP_MIN)
			&& (16'(result.temperature_centi) <= TEMP_MAX))
		else $error("temperature result outside saturation limits");

endmodule

// ----- sv/bsc_temp.sv -----
// Temperature path: linearized temperature, its 16-fraction-bit form, and the centi output.
module bsc_temp import bsc_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [23:0]        raw_temperature,
	input  trim_t              trim,
	output logic signed [27:0] t_s5,
	output logic signed [14:0] tc_s13
);

	localparam logic signed [59:0] TL_MAX = 60'sd86 <<< 48;
	localparam logic signed [59:0] TL_MIN = -(60'sd41 <<< 48);
	localparam logic signed [63:0] HALF_48 = 64'sd1 <<< 47;
	localparam logic signed [59:0] HALF_32 = 60'sd1 <<< 31;

	logic signed [24:0] d;
	logic signed [24:0] d_s1;
	logic signed [41:0] dt2_s2, dt2_s3;
	logic signed [49:0] dd_s2;
	logic signed [57:0] ddt3_s3;
	logic signed [59:0] tl_s4;
	logic signed [59:0] tr;
	logic signed [59:0] xcl;
	logic signed [59:0] xcl_s5;
	logic signed [63:0] y_s6;
	logic signed [15:0] tcw;
	logic signed [14:0] tcc;
	logic signed [14:0] tc_s7, tc_s8, tc_s9, tc_s10, tc_s11, tc_s12;

	assign d = $signed({1'b0, raw_temperature}) - $signed({1'b0, trim.t1, 8'd0});
	assign tr = tl_s4 + HALF_32;

	always_comb begin
		if (tl_s4 > TL_MAX) begin
			xcl = TL_MAX;
		end else if (tl_s4 < TL_MIN) begin
			xcl = TL_MIN;
		end else begin
			xcl = tl_s4;
		end
	end

	assign tcw = $signed(y_s6[63:48]);

	always_comb begin
		if (tcw < TEMP_MIN) begin
			tcc = 15'(TEMP_MIN);
		end else if (tcw > TEMP_MAX) begin
			tcc = 15'(TEMP_MAX);
		end else begin
			tcc = 15'(tcw);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= d;
			dt2_s2  <= d_s1 * $signed({1'b0, trim.t2});
			dd_s2   <= d_s1 * d_s1;
			dt2_s3  <= dt2_s2;
			ddt3_s3 <= dd_s2 * trim.t3;
			tl_s4   <= (60'(dt2_s3) <<< 18) + 60'(ddt3_s3);
			// Floor of tl / 2^32 after adding one half: round to nearest, ties upward.
			t_s5    <= tr[59:32];
			xcl_s5  <= xcl;
			y_s6    <= (64'(xcl_s5) <<< 6) + (64'(xcl_s5) <<< 5) + (64'(xcl_s5) <<< 2)
				+ HALF_48;
			tc_s7   <= tcc;
			tc_s8   <= tc_s7;
			tc_s9   <= tc_s8;
			tc_s10  <= tc_s9;
			tc_s11  <= tc_s10;
			tc_s12  <= tc_s11;
			tc_s13  <= tc_s12;
		end
	end

endmodule

// ----- sv/bsc_coef.sv -----
// Pressure path: the four coefficients of the cubic in linearized temperature.
module bsc_coef import bsc_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [23:0]         raw_pressure,
	input  trim_t               trim,
	output logic signed [33:0]  c3_s5,
	output logic signed [54:0]  c2_s6,
	output logic signed [83:0]  c1_s8,
	output logic signed [109:0] c0_s10
);

	logic signed [24:0]  pin;
	logic signed [16:0]  p1m, p2m;
	logic signed [24:0]  p_s1, p_s2;
	logic signed [41:0]  pp1_s1, pp1_s2, pp1_s3;
	logic signed [41:0]  pp2_s1, pp2_s2;
	logic signed [32:0]  pp3_s1, pp4_s1, pp11_s1;
	logic [47:0]         psq_s1;
	logic signed [33:0]  c3_s2, c3_s3, c3_s4;
	logic signed [54:0]  c2_s2, c2_s3, c2_s4, c2_s5;
	logic signed [57:0]  y_s2;
	logic signed [64:0]  q9_s2, q9_s3;
	logic signed [56:0]  q10_s2;
	logic signed [54:0]  zlo_s3;
	logic signed [53:0]  zhi_s3;
	logic signed [83:0]  c1_s3, c1_s4, c1_s5, c1_s6, c1_s7;
	logic signed [83:0]  z_s4;
	logic signed [109:0] c0a_s4;
	logic signed [109:0] c0_s5, c0_s6, c0_s7, c0_s8, c0_s9;

	assign pin = $signed({1'b0, raw_pressure});
	assign p1m = 17'(trim.p1) - 17'sd16384;
	assign p2m = 17'(trim.p2) - 17'sd16384;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= pin;
			pp1_s1  <= pin * p1m;
			pp2_s1  <= pin * p2m;
			pp3_s1  <= pin * trim.p3;
			pp4_s1  <= pin * trim.p4;
			pp11_s1 <= pin * trim.p11;
			psq_s1  <= raw_pressure * raw_pressure;

			p_s2   <= p_s1;
			pp1_s2 <= pp1_s1;
			pp2_s2 <= pp2_s1;
			c3_s2  <= (34'(trim.p8) <<< 22) + 34'(pp4_s1);
			c2_s2  <= (55'(trim.p7) <<< 45) + (55'(pp3_s1) <<< 21);
			y_s2   <= pp11_s1 * p_s1;
			q9_s2  <= $signed({1'b0, psq_s1}) * trim.p9;
			q10_s2 <= $signed({1'b0, psq_s1}) * trim.p10;

			// The cubic pressure term is split in two partial products.
			zlo_s3 <= $signed({1'b0, y_s2[28:0]}) * p_s2;
			zhi_s3 <= $signed(y_s2[57:29]) * p_s2;
			c1_s3  <= (84'($signed({1'b0, trim.p6})) <<< 63) + (84'(pp2_s2) <<< 40)
				+ (84'(q10_s2) <<< 21);
			pp1_s3 <= pp1_s2;
			q9_s3  <= q9_s2;
			c3_s3  <= c3_s2;
			c2_s3  <= c2_s2;

			z_s4   <= (84'(zhi_s3) <<< 29) + 84'(zlo_s3);
			c0a_s4 <= (110'($signed({1'b0, trim.p5})) <<< 88) + (110'(pp1_s3) <<< 65)
				+ (110'(q9_s3) <<< 37);
			c3_s4  <= c3_s3;
			c2_s4  <= c2_s3;
			c1_s4  <= c1_s3;

			c0_s5 <= c0a_s4 + (110'(z_s4) <<< 20);
			c3_s5 <= c3_s4;
			c2_s5 <= c2_s4;
			c1_s5 <= c1_s4;

			c2_s6  <= c2_s5;
			c1_s6  <= c1_s5;
			c0_s6  <= c0_s5;
			c1_s7  <= c1_s6;
			c0_s7  <= c0_s6;
			c1_s8  <= c1_s7;
			c0_s8  <= c0_s7;
			c0_s9  <= c0_s8;
			c0_s10 <= c0_s9;
		end
	end

endmodule

// ----- sv/bsc_horner.sv -----
// Horner evaluation of the pressure cubic, scaling to 0.01 Pa, rounding and saturation.
module bsc_horner import bsc_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic signed [27:0]  t_s5,
	input  logic signed [33:0]  c3_s5,
	input  logic signed [54:0]  c2_s6,
	input  logic signed [83:0]  c1_s8,
	input  logic signed [109:0] c0_s10,
	output logic [23:0]         pc_s13
);

	localparam logic signed [127:0] HALF_85 = 128'sd1 <<< 84;

	logic signed [27:0]  t_s6, t_s7, t_s8, t_s9;
	logic signed [61:0]  a2p_s6;
	logic signed [62:0]  a2_s7;
	logic signed [60:0]  mlo_s8;
	logic signed [58:0]  mhi_s8;
	logic signed [91:0]  a1_s9;
	logic signed [59:0]  n0_s10, n1_s10;
	logic signed [57:0]  n2_s10;
	logic signed [119:0] a0_s11;
	logic signed [127:0] s100_s12;
	logic signed [127:0] rnd;
	logic [42:0]         pr;
	logic [23:0]         pc;

	assign rnd = s100_s12 + HALF_85;
	assign pr = rnd[127:85];

	always_comb begin
		if (s100_s12 < 128'sd0) begin
			pc = '0;
		end else if (pr > 43'(PRESS_MAX)) begin
			pc = PRESS_MAX;
		end else begin
			pc = pr[23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s6   <= t_s5;
			a2p_s6 <= c3_s5 * t_s5;

			t_s7  <= t_s6;
			a2_s7 <= 63'(a2p_s6) + 63'(c2_s6);

			t_s8   <= t_s7;
			mlo_s8 <= $signed({1'b0, a2_s7[31:0]}) * t_s7;
			mhi_s8 <= $signed(a2_s7[62:32]) * t_s7;

			t_s9  <= t_s8;
			a1_s9 <= (92'(mhi_s8) <<< 32) + 92'(mlo_s8) + 92'(c1_s8);

			n0_s10 <= $signed({1'b0, a1_s9[30:0]}) * t_s9;
			n1_s10 <= $signed({1'b0, a1_s9[61:31]}) * t_s9;
			n2_s10 <= $signed(a1_s9[91:62]) * t_s9;

			a0_s11 <= (120'(n2_s10) <<< 62) + (120'(n1_s10) <<< 31) + 120'(n0_s10)
				+ 120'(c0_s10);

			// Times 100 as 64 + 32 + 4.
			s100_s12 <= (128'(a0_s11) <<< 6) + (128'(a0_s11) <<< 5) + (128'(a0_s11) <<< 2);

			pc_s13 <= pc;
		end
	end

endmodule
